// ===== src/cnr_pkg.sv =====
// Shared types, constants and command/status structs for the cubic Newton root solver.
`default_nettype none
package cnr_pkg;

    typedef struct packed {
        logic signed [31:0] coef_cubic;
        logic signed [31:0] coef_square;
    } cnr_in_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic        [7:0]  steps;
        logic               not_converged;
        logic               zero_slope;
    } cnr_out_t;

    localparam int unsigned IDX_TOLERANCE = 0;
    localparam int unsigned IDX_MAX_ITER  = 1;
    localparam logic [24:0] TOL_RESET     = 25'd168;
    localparam logic [7:0]  MAXIT_RESET   = 8'd32;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 25;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_MUL   = 4'd2,
        OP_SUMF  = 4'd3,
        OP_SUMD  = 4'd4,
        OP_DIVGO = 4'd5,
        OP_UPD   = 4'd6,
        OP_TEST  = 4'd7
    } cnr_op_t;

    // Multiplier operand / destination selects
    typedef enum logic [2:0] {
        M_XX  = 3'd0,
        M_X2X = 3'd1,
        M_AX3 = 3'd2,
        M_BX2 = 3'd3,
        M_AX2 = 3'd4,
        M_BX  = 3'd5
    } cnr_msel_t;

    typedef struct packed {
        cnr_op_t   op;
        cnr_msel_t msel;
    } cnr_cmd_t;

    typedef struct packed {
        logic d_zero;
        logic div_done;
        logic converged;
    } cnr_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/cnr_div.sv =====
// Restoring radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module cnr_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [DEN_W-1:0] den,
    output logic                         done,
    output logic signed [NUM_W-1:0]      quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] sub;

    always_comb
    begin
        trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        sub   = {1'b0, trial} - {2'b00, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NUM_W-1] ? NUM_W'(-num) : num;
            d_reg   <= den[DEN_W-1] ? DEN_W'(-den) : den;
            r_reg   <= '0;
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            if (!sub[DEN_W+1])
            begin
                r_reg <= sub[DEN_W:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign quo = neg_reg ? NUM_W'(-q_reg) : q_reg;
endmodule
`default_nettype wire

// ===== src/cnr_datapath.sv =====
// Datapath: shared multiplier, sums, divider, update and convergence test.
`default_nettype none
module cnr_datapath #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cnr_pkg::cnr_cmd_t cmd,
    input  wire cnr_pkg::cnr_in_t  in_item,
    input  wire logic [24:0]     tol,
    output cnr_pkg::cnr_stat_t   stat,
    output logic signed [31:0]   x_out
);
    import cnr_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS + 2;
    localparam int CMP_W = (33 + FRAC_BITS > 58) ? 33 + FRAC_BITS : 58;

    logic signed [31:0] a_reg, b_reg, x_reg, xn_reg;
    logic signed [31:0] x2_reg, x3_reg, ax3_reg, bx2_reg, ax2_reg, bx_reg;
    logic signed [31:0] f_reg, d_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [31:0] prod_s;
    logic signed [NUM_W:0] sumf, sumd;
    logic signed [NUM_W-1:0] num, quo;
    logic signed [NUM_W:0]   xn_wide;
    logic        [32:0] diff_mag, xn_mag;
    logic        [CMP_W-1:0] lhs;
    logic        [CMP_W-1:0] rhs;
    logic div_done;

    // Saturate a wide signed value into 32 bits
    function automatic logic signed [31:0] satw(input logic signed [NUM_W:0] v);
        if (v > (NUM_W+1)'(32'sh7fffffff))
            satw = 32'sh7fffffff;
        else if (v < (NUM_W+1)'(32'sh80000000))
            satw = 32'sh80000000;
        else
            satw = v[31:0];
    endfunction

    always_comb
    begin
        case (cmd.msel)
            M_XX:    begin ma = x_reg;  mb = x_reg;  end
            M_X2X:   begin ma = x2_reg; mb = x_reg;  end
            M_AX3:   begin ma = a_reg;  mb = x3_reg; end
            M_BX2:   begin ma = b_reg;  mb = x2_reg; end
            M_AX2:   begin ma = a_reg;  mb = x2_reg; end
            M_BX:    begin ma = b_reg;  mb = x_reg;  end
            default: begin ma = x_reg;  mb = x_reg;  end
        endcase
        prod   = ma * mb;
        prod_s = satw((NUM_W+1)'(prod >>> FRAC_BITS));
        sumf = (NUM_W+1)'(ax3_reg) + (NUM_W+1)'(bx2_reg)
             + (NUM_W+1)'(x_reg) * (NUM_W+1)'(6)
             + ((NUM_W+1)'(80) <<< FRAC_BITS);
        sumd = (NUM_W+1)'(ax2_reg) * (NUM_W+1)'(3)
             + (NUM_W+1)'(bx_reg) * (NUM_W+1)'(2)
             + ((NUM_W+1)'(6) <<< FRAC_BITS);
        num     = NUM_W'(f_reg) <<< FRAC_BITS;
        xn_wide = (NUM_W+1)'(x_reg) - (NUM_W+1)'(quo);
        diff_mag = (xn_reg >= x_reg) ? 33'(34'(xn_reg) - 34'(x_reg))
                                     : 33'(34'(x_reg) - 34'(xn_reg));
        xn_mag   = xn_reg[31] ? 33'(-34'(xn_reg)) : 33'(xn_reg);
        lhs = CMP_W'(diff_mag) << FRAC_BITS;
        rhs = CMP_W'(tol) * CMP_W'(xn_mag);
    end

    cnr_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIVGO),
        .num   (num),
        .den   (d_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                a_reg <= in_item.coef_cubic;
                b_reg <= in_item.coef_square;
                x_reg <= '0;
            end
            OP_MUL:
            begin
                case (cmd.msel)
                    M_XX:    x2_reg  <= prod_s;
                    M_X2X:   x3_reg  <= prod_s;
                    M_AX3:   ax3_reg <= prod_s;
                    M_BX2:   bx2_reg <= prod_s;
                    M_AX2:   ax2_reg <= prod_s;
                    M_BX:    bx_reg  <= prod_s;
                    default: x2_reg  <= prod_s;
                endcase
            end
            OP_SUMF: f_reg  <= satw(sumf);
            OP_SUMD: d_reg  <= satw(sumd);
            OP_UPD:  xn_reg <= satw(xn_wide);
            OP_TEST: x_reg  <= xn_reg;
            default: ;
        endcase
    end

    assign stat.d_zero    = (d_reg == 32'sd0);
    assign stat.div_done  = div_done;
    assign stat.converged = (lhs <= rhs);
    assign x_out          = x_reg;
endmodule
`default_nettype wire

// ===== src/cnr_ctrl.sv =====
// Controller: sequences each Newton step and the item handshakes.
`default_nettype none
module cnr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic [7:0]        max_iter,
    input  wire cnr_pkg::cnr_stat_t stat,
    output cnr_pkg::cnr_cmd_t      cmd,
    output logic [7:0]             steps,
    output logic                   not_converged,
    output logic                   zero_slope
);
    import cnr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CHK  = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_SUM  = 9'b000001000,
        S_DZ   = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_TEST = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t    state_reg, state_next;
    cnr_msel_t msel_reg, msel_next;
    logic [7:0] steps_reg, steps_next;
    logic nc_reg, nc_next, zs_reg, zs_next, sumd_reg, sumd_next;

    always_comb
    begin
        state_next = state_reg;
        msel_next  = msel_reg;
        steps_next = steps_reg;
        nc_next    = nc_reg;
        zs_next    = zs_reg;
        sumd_next  = sumd_reg;
        cmd.op     = OP_NONE;
        cmd.msel   = msel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    steps_next = '0;
                    nc_next    = 1'b0;
                    zs_next    = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (steps_reg >= max_iter)
                begin
                    nc_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    msel_next  = M_XX;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                case (msel_reg)
                    M_XX:    msel_next = M_X2X;
                    M_X2X:   msel_next = M_AX3;
                    M_AX3:   msel_next = M_BX2;
                    M_BX2:   msel_next = M_AX2;
                    M_AX2:   msel_next = M_BX;
                    default:
                    begin
                        sumd_next  = 1'b0;
                        state_next = S_SUM;
                    end
                endcase
            end
            S_SUM:
            begin
                cmd.op = sumd_reg ? OP_SUMD : OP_SUMF;
                sumd_next = 1'b1;
                if (sumd_reg)
                    state_next = S_DZ;
            end
            S_DZ:
            begin
                if (stat.d_zero)
                begin
                    zs_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = OP_DIVGO;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op     = OP_UPD;
                steps_next = steps_reg + 8'd1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.op     = OP_TEST;
                state_next = stat.converged ? S_OUT : S_CHK;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            msel_reg  <= M_XX;
            steps_reg <= '0;
            nc_reg    <= 1'b0;
            zs_reg    <= 1'b0;
            sumd_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            msel_reg  <= msel_next;
            steps_reg <= steps_next;
            nc_reg    <= nc_next;
            zs_reg    <= zs_next;
            sumd_reg  <= sumd_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign steps         = steps_reg;
    assign not_converged = nc_reg;
    assign zero_slope    = zs_reg;
endmodule
`default_nettype wire

// ===== src/cubic_newton_root_solver.sv =====
// Top level of the cubic Newton root solver: config registers, controller and datapath.
`default_nettype none
// Solves a*x^3 + b*x^2 + 6x + 80 = 0 by Newton iteration from x = 0 in signed
// fixed point with FRAC_BITS fraction bits, one item at a time. Each step
// runs a cap check, six products on the shared 32x32 multiplier, the f
// and f' sums, a derivative check, the bit-serial divider and then the
// update and relative test. An item is loaded, runs its steps, makes one
// more cap check when the cap ends the run, and then waits on the output.
// The result stays on the output until taken; a new item is accepted after
// that. Write tolerance and max_iterations only while the block is idle.
module cubic_newton_root_solver #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cnr_pkg::cnr_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cnr_pkg::cnr_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_idx,
    input  wire logic [24:0]       cfg_wdata
);
    import cnr_pkg::*;

    logic [24:0] tol_reg;
    logic [7:0]  maxit_reg;
    cnr_cmd_t    cmd;
    cnr_stat_t   stat;
    logic signed [31:0] x;

    // Hold the configuration registers; write them only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            maxit_reg <= MAXIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_IDX_W'(IDX_TOLERANCE))
                tol_reg <= cfg_wdata;
            else
                maxit_reg <= cfg_wdata[7:0];
        end
    end

    cnr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .max_iter      (maxit_reg),
        .stat          (stat),
        .cmd           (cmd),
        .steps         (out_data.steps),
        .not_converged (out_data.not_converged),
        .zero_slope    (out_data.zero_slope)
    );

    cnr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_item (in_data),
        .tol     (tol_reg),
        .stat    (stat),
        .x_out   (x)
    );

    assign out_data.root = x;
endmodule
`default_nettype wire
